@@ rtl/core/hsvrgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared types and constants for the HSV to RGB pixel converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

    // Hue field and sector split
    localparam int HUE_BITS    = 13;
    localparam int SECTOR_BITS = 4;
    localparam int FRAC_BITS   = 10;
    localparam int NUM_SECTORS_MAX = 8;   // highest sector a 13-bit hue can reach

    typedef logic [HUE_BITS-1:0]    t_hue;
    typedef logic [SECTOR_BITS-1:0] t_sector;
    typedef logic [FRAC_BITS-1:0]   t_frac;

    // One 60-degree sector in sixteenths of a degree
    localparam t_frac SECTOR_UNITS = 10'd960;

    // Sector codes for the output select; everything above SECTOR_4 is the
    // default arrangement
    localparam t_sector SECTOR_0 = 4'd0;
    localparam t_sector SECTOR_1 = 4'd1;
    localparam t_sector SECTOR_2 = 4'd2;
    localparam t_sector SECTOR_3 = 4'd3;
    localparam t_sector SECTOR_4 = 4'd4;

endpackage

`default_nettype wire

@@ rtl/core/hsv_to_rgb_converter_unit.sv @@
// Pipeline: 7 register stages: one sector split, two multiply, three divide
// (estimate, back-multiply, correction), one output. Throughput: one pixel per
// clock; the whole pipeline advances together and holds while the output
// register carries a result that is not taken. Reset (synchronous, active low)
// clears all valid bits only.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// HSV to RGB pixel converter, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_unit #(
    parameter int COLOR_BITS = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // Input pixel channel
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire hsvrgb_pkg::t_hue        i_hue,
    input  wire logic [COLOR_BITS-1:0]   i_saturation,
    input  wire logic [COLOR_BITS-1:0]   i_brightness,
    // Output pixel channel
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [COLOR_BITS-1:0]        o_red,
    output logic [COLOR_BITS-1:0]        o_green,
    output logic [COLOR_BITS-1:0]        o_blue
);
    import hsvrgb_pkg::*;

    localparam int NW = 2 * COLOR_BITS + FRAC_BITS;

    logic                    w_en;
    logic                    s1_valid;
    t_sector                 s1_sector;
    t_frac                   s1_frac;
    logic [COLOR_BITS-1:0]   s1_sat;
    logic [COLOR_BITS-1:0]   s1_val;
    logic                    m_valid;
    t_sector                 m_sector;
    logic [COLOR_BITS-1:0]   m_val;
    logic [NW-1:0]           m_num_p;
    logic [NW-1:0]           m_num_q;
    logic [NW-1:0]           m_num_t;
    logic                    d_valid;
    t_sector                 d_sector;
    logic [COLOR_BITS-1:0]   d_val;
    logic [COLOR_BITS-1:0]   d_p;
    logic [COLOR_BITS-1:0]   d_q;
    logic [COLOR_BITS-1:0]   d_t;

    logic                    r_out_valid;
    logic [COLOR_BITS-1:0]   r_red;
    logic [COLOR_BITS-1:0]   r_green;
    logic [COLOR_BITS-1:0]   r_blue;
    logic [COLOR_BITS-1:0]   n_red;
    logic [COLOR_BITS-1:0]   n_green;
    logic [COLOR_BITS-1:0]   n_blue;

    // Pipeline moves whenever the output register is empty or being drained
    assign w_en    = !r_out_valid || i_ready;
    assign o_ready = w_en;

    hsvrgb_sector #(.COLOR_BITS(COLOR_BITS)) u_sector (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_valid),
        .i_hue    (i_hue),
        .i_sat    (i_saturation),
        .i_val    (i_brightness),
        .o_valid  (s1_valid),
        .o_sector (s1_sector),
        .o_frac   (s1_frac),
        .o_sat    (s1_sat),
        .o_val    (s1_val)
    );

    hsvrgb_mult #(.COLOR_BITS(COLOR_BITS)) u_mult (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (s1_valid),
        .i_sector (s1_sector),
        .i_frac   (s1_frac),
        .i_sat    (s1_sat),
        .i_val    (s1_val),
        .o_valid  (m_valid),
        .o_sector (m_sector),
        .o_val    (m_val),
        .o_num_p  (m_num_p),
        .o_num_q  (m_num_q),
        .o_num_t  (m_num_t)
    );

    hsvrgb_divider #(.COLOR_BITS(COLOR_BITS)) u_divider (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (m_valid),
        .i_sector (m_sector),
        .i_val    (m_val),
        .i_num_p  (m_num_p),
        .i_num_q  (m_num_q),
        .i_num_t  (m_num_t),
        .o_valid  (d_valid),
        .o_sector (d_sector),
        .o_val    (d_val),
        .o_quo_p  (d_p),
        .o_quo_q  (d_q),
        .o_quo_t  (d_t)
    );

    // Six-way select; zero saturation needs no special path since p, q and t
    // all come out equal to v
    always_comb begin
        case (d_sector)
            SECTOR_0: begin
                n_red = d_val; n_green = d_t;   n_blue = d_p;
            end
            SECTOR_1: begin
                n_red = d_q;   n_green = d_val; n_blue = d_p;
            end
            SECTOR_2: begin
                n_red = d_p;   n_green = d_val; n_blue = d_t;
            end
            SECTOR_3: begin
                n_red = d_p;   n_green = d_q;   n_blue = d_val;
            end
            SECTOR_4: begin
                n_red = d_t;   n_green = d_p;   n_blue = d_val;
            end
            default: begin
                n_red = d_val; n_green = d_p;   n_blue = d_q;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_valid = r_out_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

`default_nettype wire

@@ rtl/core/hsvrgb_sector.sv @@
// ----------------------------------------------------------------------------
// hsvrgb_sector
// First pipeline stage: splits the hue into sector index and offset within
// the sector, and registers saturation and value alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_sector #(
    parameter int COLOR_BITS = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_valid,
    input  wire hsvrgb_pkg::t_hue        i_hue,
    input  wire logic [COLOR_BITS-1:0]   i_sat,
    input  wire logic [COLOR_BITS-1:0]   i_val,
    output logic                         o_valid,
    output hsvrgb_pkg::t_sector          o_sector,
    output hsvrgb_pkg::t_frac            o_frac,
    output logic [COLOR_BITS-1:0]        o_sat,
    output logic [COLOR_BITS-1:0]        o_val
);
    import hsvrgb_pkg::*;

    t_sector                 n_sector;
    t_hue                    n_rem;
    logic                    r_valid;
    t_sector                 r_sector;
    t_frac                   r_frac;
    logic [COLOR_BITS-1:0]   r_sat;
    logic [COLOR_BITS-1:0]   r_val;

    // Sector = number of sector boundaries at or below the hue
    always_comb begin
        n_sector = '0;
        for (int k = 1; k <= NUM_SECTORS_MAX; k++) begin
            if (i_hue >= HUE_BITS'(k * int'(SECTOR_UNITS))) begin
                n_sector = SECTOR_BITS'(k);
            end
        end
        n_rem = i_hue - HUE_BITS'(int'(n_sector) * int'(SECTOR_UNITS));
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sector <= n_sector;
            r_frac   <= n_rem[FRAC_BITS-1:0];
            r_sat    <= i_sat;
            r_val    <= i_val;
        end
    end

    assign o_valid  = r_valid;
    assign o_sector = r_sector;
    assign o_frac   = r_frac;
    assign o_sat    = r_sat;
    assign o_val    = r_val;

endmodule

`default_nettype wire

@@ rtl/core/hsvrgb_mult.sv @@
// ----------------------------------------------------------------------------
// hsvrgb_mult
// Two multiply stages that build the numerators of p, q and t over the
// common divisor CMAX*960.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_mult #(
    parameter int COLOR_BITS = 8
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_en,
    input  wire logic                                     i_valid,
    input  wire hsvrgb_pkg::t_sector                      i_sector,
    input  wire hsvrgb_pkg::t_frac                        i_frac,
    input  wire logic [COLOR_BITS-1:0]                    i_sat,
    input  wire logic [COLOR_BITS-1:0]                    i_val,
    output logic                                          o_valid,
    output hsvrgb_pkg::t_sector                           o_sector,
    output logic [COLOR_BITS-1:0]                         o_val,
    output logic [2*COLOR_BITS+hsvrgb_pkg::FRAC_BITS-1:0] o_num_p,
    output logic [2*COLOR_BITS+hsvrgb_pkg::FRAC_BITS-1:0] o_num_q,
    output logic [2*COLOR_BITS+hsvrgb_pkg::FRAC_BITS-1:0] o_num_t
);
    import hsvrgb_pkg::*;

    localparam int PW       = 2 * COLOR_BITS;           // v*(CMAX-s)
    localparam int SW       = COLOR_BITS + FRAC_BITS;   // s*frac, full scale
    localparam int NW       = PW + FRAC_BITS;           // numerators
    localparam int CMAX_INT = (1 << COLOR_BITS) - 1;
    localparam logic [COLOR_BITS-1:0] CMAX = COLOR_BITS'(CMAX_INT);
    localparam logic [SW-1:0]         FULL = SW'(CMAX_INT * int'(SECTOR_UNITS));

    // Stage A registers
    logic                    r_a_valid;
    t_sector                 r_a_sector;
    logic [COLOR_BITS-1:0]   r_a_val;
    logic [PW-1:0]           r_a_pm;
    logic [SW-1:0]           r_a_sq;
    logic [SW-1:0]           r_a_st;
    // Stage B registers
    logic                    r_b_valid;
    t_sector                 r_b_sector;
    logic [COLOR_BITS-1:0]   r_b_val;
    logic [NW-1:0]           r_b_np;
    logic [NW-1:0]           r_b_nq;
    logic [NW-1:0]           r_b_nt;

    logic [PW-1:0]           n_pm;
    logic [SW-1:0]           n_sq;
    logic [SW-1:0]           n_st;
    logic [NW-1:0]           n_np;
    logic [NW-1:0]           n_nq;
    logic [NW-1:0]           n_nt;

    // Stage A: v*(CMAX-s), s*frac, s*(960-frac)
    always_comb begin
        n_pm = PW'(i_val) * PW'(CMAX - i_sat);
        n_sq = SW'(i_sat) * SW'(i_frac);
        n_st = SW'(i_sat) * SW'(SECTOR_UNITS - i_frac);
    end

    // Stage B: scale p by 960 (shift-subtract), v*(full - s*frac) etc.
    always_comb begin
        n_np = (NW'(r_a_pm) << FRAC_BITS) - (NW'(r_a_pm) << 6);
        n_nq = NW'(r_a_val) * NW'(FULL - r_a_sq);
        n_nt = NW'(r_a_val) * NW'(FULL - r_a_st);
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_sector <= i_sector;
            r_a_val    <= i_val;
            r_a_pm     <= n_pm;
            r_a_sq     <= n_sq;
            r_a_st     <= n_st;
            r_b_sector <= r_a_sector;
            r_b_val    <= r_a_val;
            r_b_np     <= n_np;
            r_b_nq     <= n_nq;
            r_b_nt     <= n_nt;
        end
    end

    assign o_valid  = r_b_valid;
    assign o_sector = r_b_sector;
    assign o_val    = r_b_val;
    assign o_num_p  = r_b_np;
    assign o_num_q  = r_b_nq;
    assign o_num_t  = r_b_nt;

endmodule

`default_nettype wire

@@ rtl/core/hsvrgb_divider.sv @@
// ----------------------------------------------------------------------------
// hsvrgb_divider
// Three-stage divider by the constant CMAX*960 for the p, q and t lanes: a
// reciprocal-multiply estimate from the top numerator bits, a back-multiply,
// then a single correction step.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_divider #(
    parameter int COLOR_BITS = 8
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_en,
    input  wire logic                                     i_valid,
    input  wire hsvrgb_pkg::t_sector                      i_sector,
    input  wire logic [COLOR_BITS-1:0]                    i_val,
    input  wire logic [2*COLOR_BITS+hsvrgb_pkg::FRAC_BITS-1:0] i_num_p,
    input  wire logic [2*COLOR_BITS+hsvrgb_pkg::FRAC_BITS-1:0] i_num_q,
    input  wire logic [2*COLOR_BITS+hsvrgb_pkg::FRAC_BITS-1:0] i_num_t,
    output logic                                          o_valid,
    output hsvrgb_pkg::t_sector                           o_sector,
    output logic [COLOR_BITS-1:0]                         o_val,
    output logic [COLOR_BITS-1:0]                         o_quo_p,
    output logic [COLOR_BITS-1:0]                         o_quo_q,
    output logic [COLOR_BITS-1:0]                         o_quo_t
);
    import hsvrgb_pkg::*;

    localparam int NW       = 2 * COLOR_BITS + FRAC_BITS;
    localparam int NL       = 3;                  // lanes p, q, t
    localparam int SH       = COLOR_BITS + 8;     // numerator bits dropped for the estimate
    localparam int KS       = COLOR_BITS + 6;     // reciprocal scale
    localparam int HW       = NW - SH;
    localparam int MW       = COLOR_BITS + 5;
    localparam int PW       = HW + MW;
    localparam int CMAX_INT = (1 << COLOR_BITS) - 1;
    localparam longint unsigned DIV_L = longint'(CMAX_INT) * longint'(SECTOR_UNITS);
    localparam longint unsigned REC_L = (64'd1 << (SH + KS)) / DIV_L;
    localparam logic [NW-1:0] DIVISOR = NW'(DIV_L);
    localparam logic [MW-1:0] RECIP   = MW'(REC_L);

    // Estimate is low by at most one: the dropped numerator bits and the
    // truncated reciprocal together lose less than one quotient unit

    logic                    r_a_valid;
    logic                    r_b_valid;
    logic                    r_c_valid;
    t_sector                 r_a_sector;
    t_sector                 r_b_sector;
    t_sector                 r_c_sector;
    logic [COLOR_BITS-1:0]   r_a_val;
    logic [COLOR_BITS-1:0]   r_b_val;
    logic [COLOR_BITS-1:0]   r_c_val;
    logic [NW-1:0]           r_a_num  [NL];
    logic [NW-1:0]           r_b_num  [NL];
    logic [NW-1:0]           r_b_lim  [NL];
    logic [COLOR_BITS-1:0]   r_a_quo  [NL];
    logic [COLOR_BITS-1:0]   r_b_quo  [NL];
    logic [COLOR_BITS-1:0]   r_c_quo  [NL];

    logic [NW-1:0]           w_num    [NL];
    logic [PW-1:0]           n_prod   [NL];
    logic [COLOR_BITS-1:0]   n_est    [NL];
    logic [NW-1:0]           n_lim    [NL];
    logic [COLOR_BITS-1:0]   n_quo    [NL];

    assign w_num[0] = i_num_p;
    assign w_num[1] = i_num_q;
    assign w_num[2] = i_num_t;

    // Stage a: estimate; stage b: (estimate+1)*divisor; stage c: correct
    always_comb begin
        for (int ln = 0; ln < NL; ln++) begin
            n_prod[ln] = PW'(w_num[ln][NW-1:SH]) * PW'(RECIP);
            n_est[ln]  = n_prod[ln][KS +: COLOR_BITS];
            n_lim[ln]  = NW'(r_a_quo[ln]) * DIVISOR + DIVISOR;
            n_quo[ln]  = (r_b_num[ln] >= r_b_lim[ln]) ?
                         r_b_quo[ln] + COLOR_BITS'(1) : r_b_quo[ln];
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_sector <= i_sector;
            r_a_val    <= i_val;
            r_b_sector <= r_a_sector;
            r_b_val    <= r_a_val;
            r_c_sector <= r_b_sector;
            r_c_val    <= r_b_val;
            for (int ln = 0; ln < NL; ln++) begin
                r_a_num[ln] <= w_num[ln];
                r_a_quo[ln] <= n_est[ln];
                r_b_num[ln] <= r_a_num[ln];
                r_b_quo[ln] <= r_a_quo[ln];
                r_b_lim[ln] <= n_lim[ln];
                r_c_quo[ln] <= n_quo[ln];
            end
        end
    end

    assign o_valid  = r_c_valid;
    assign o_sector = r_c_sector;
    assign o_val    = r_c_val;
    assign o_quo_p  = r_c_quo[0];
    assign o_quo_q  = r_c_quo[1];
    assign o_quo_t  = r_c_quo[2];

endmodule

`default_nettype wire
